// File: rtl/core/adfg_pkg.sv
// Shared types and constants for the attack/decay function generator.
package adfg_pkg;

   localparam int LEVEL_FRAC_BITS_DEF = 23;
   localparam int SAMPLES_W           = 24;
   localparam int LEVEL_OUT_W         = 24;
   localparam int CSR_ADDR_W          = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_MODE       = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTACK_SAMPLES = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_SAMPLES  = 2'd2;

   // Run mode codes; any other code behaves as transient.
   localparam logic [1:0] MODE_SUSTAIN = 2'd1;
   localparam logic [1:0] MODE_CYCLE   = 2'd2;

   typedef enum logic [3:0] {
      ENV_IDLE    = 4'b0001,
      ENV_ATTACK  = 4'b0010,
      ENV_SUSTAIN = 4'b0100,
      ENV_DECAY   = 4'b1000
   } env_stage_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: rtl/core/attack_decay_function_generator.sv
// Linear attack/decay envelope generator with transient, sustain and cycle modes.
// An attack or decay beat runs through the step divider, which forms one quotient bit per
// cycle, and then the update state before its result is registered; idle and sustain beats
// skip the divider. A new beat is accepted only once the last has left the update state; a
// finished result waits in the output register and the next beat is accepted meanwhile.
// Reset sets sequencer and stage to idle, level to zero, clears configuration and output valid.
module attack_decay_function_generator #(
   parameter int LEVEL_FRAC_BITS = adfg_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [0] trigger_pulse, [1] gate_high
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [adfg_pkg::LEVEL_OUT_W-1:0]    rsp_tdata,  // [23:0] level
   output logic                                rsp_tlast,  // end_pulse
   input  logic                                csr_we,
   input  logic [adfg_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [adfg_pkg::SAMPLES_W-1:0]      csr_wdata
);
   import adfg_pkg::*;

   localparam int LW = LEVEL_FRAC_BITS + 1;
   localparam logic [LW-1:0] FullScale = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_CALC = 3'b100
   } seq_state_type;

   seq_state_type        state_ff, state_in;
   env_stage_type        stage_ff, stage_in;
   env_stage_type        eff_ff, eff_in;
   logic [LW-1:0]        level_ff, level_in;
   logic                 gate_ff, gate_in;
   logic [1:0]           mode_ff, mode_in;
   logic [SAMPLES_W-1:0] attack_ff, attack_in;
   logic [SAMPLES_W-1:0] decay_ff, decay_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_OUT_W-1:0] rsp_level_ff, rsp_level_in;
   logic                 rsp_end_ff, rsp_end_in;

   logic                 req_fire;
   logic                 out_free;
   env_stage_type        req_stage;
   logic                 div_start;
   logic [SAMPLES_W-1:0] div_samples;
   logic [LW-1:0]        step;
   div_stat_type         div_stat;
   logic [LW:0]          sum;
   logic [LW-1:0]        calc_level;
   env_stage_type        calc_stage;
   logic                 calc_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_stage  = req_tdata[0] ? ENV_ATTACK : stage_ff;
   assign div_start  = req_fire && (req_stage == ENV_ATTACK || req_stage == ENV_DECAY);
   assign div_samples = (req_stage == ENV_ATTACK) ? attack_ff : decay_ff;

   adfg_div #(
      .FRAC_BITS (LEVEL_FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (div_samples),
      .quotient (step),
      .stat     (div_stat)
   );

   // Configuration writes.
   always_comb begin
      mode_in   = mode_ff;
      attack_in = attack_ff;
      decay_in  = decay_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_RUN_MODE:       mode_in   = csr_wdata[1:0];
            CSR_ATTACK_SAMPLES: attack_in = csr_wdata;
            CSR_DECAY_SAMPLES:  decay_in  = csr_wdata;
            default:            ;
         endcase
      end
   end

   // Envelope update for the captured beat.
   assign sum = {1'b0, level_ff} + {1'b0, step};

   always_comb begin
      calc_level = level_ff;
      calc_stage = eff_ff;
      calc_end   = 1'b0;
      unique case (eff_ff)
         ENV_IDLE: begin
            calc_level = '0;
         end
         ENV_ATTACK: begin
            if (sum >= {1'b0, FullScale}) begin
               calc_level = FullScale;
               calc_stage = (mode_ff == MODE_SUSTAIN) ? ENV_SUSTAIN : ENV_DECAY;
            end else begin
               calc_level = sum[LW-1:0];
            end
         end
         ENV_SUSTAIN: begin
            calc_level = FullScale;
            if (!gate_ff) calc_stage = ENV_DECAY;
         end
         ENV_DECAY: begin
            if (step >= level_ff) begin
               calc_level = '0;
               calc_end   = 1'b1;
               calc_stage = (mode_ff == MODE_CYCLE) ? ENV_ATTACK : ENV_IDLE;
            end else begin
               calc_level = level_ff - step;
            end
         end
         default: ;
      endcase
   end

   // Sequencer and output register.
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      level_in     = level_ff;
      eff_in       = eff_ff;
      gate_in      = gate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_end_in   = rsp_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               eff_in   = req_stage;
               gate_in  = req_tdata[1];
               state_in = div_start ? ST_DIV : ST_CALC;
            end
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_CALC;
         end
         ST_CALC: begin
            if (out_free) begin
               stage_in     = calc_stage;
               level_in     = calc_level;
               rsp_valid_in = 1'b1;
               rsp_level_in = LEVEL_OUT_W'(calc_level);
               rsp_end_in   = calc_end;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= ENV_IDLE;
         level_ff     <= '0;
         mode_ff      <= '0;
         attack_ff    <= '0;
         decay_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         level_ff     <= level_in;
         mode_ff      <= mode_in;
         attack_ff    <= attack_in;
         decay_ff     <= decay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eff_ff       <= eff_in;
      gate_ff      <= gate_in;
      rsp_level_ff <= rsp_level_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tlast  = rsp_end_ff;

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= FullScale)
      else $error("envelope level above full scale");

   a_sustain_full: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == ENV_SUSTAIN) |-> (level_ff == FullScale))
      else $error("sustain stage without full-scale level");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_end_at_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CALC && out_free && calc_end) |=> (level_ff == '0 && rsp_tvalid))
      else $error("end pulse without the level reaching zero");

endmodule

// File: rtl/core/adfg_div.sv
// Bit-serial restoring divider that forms floor(2^FRAC_BITS / max(1, divisor)).
module adfg_div #(
   parameter int FRAC_BITS = adfg_pkg::LEVEL_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [adfg_pkg::SAMPLES_W-1:0]   divisor,
   output logic [FRAC_BITS:0]               quotient,
   output adfg_pkg::div_stat_type           stat
);
   import adfg_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CntTop = CNT_W'(FRAC_BITS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SAMPLES_W-1:0] div_ff, div_in;
   logic [SAMPLES_W-1:0] rem_ff, rem_in;
   logic [FRAC_BITS:0]   quo_ff, quo_in;
   logic [SAMPLES_W:0]   shifted;
   logic                 fits;

   // The dividend is a single one at the top bit, so only the first step shifts in a one.
   assign shifted = {rem_ff, (cnt_ff == CntTop)};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntTop;
         div_in  = (divisor == '0) ? SAMPLES_W'(1) : divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? SAMPLES_W'(shifted - {1'b0, div_ff}) : SAMPLES_W'(shifted);
         quo_in = {quo_ff[FRAC_BITS-1:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: dv/attack_decay_function_generator_tb.sv
// Self-checking testbench for the attack/decay envelope generator, with its own envelope predictor.
module attack_decay_function_generator_tb;
   import adfg_pkg::*;

   localparam logic [1:0]  MODE_TRANSIENT = 2'd0;
   localparam logic [1:0]  MODE_UNUSED    = 2'd3;
   localparam logic [24:0] FULL_SCALE     = 25'd1 << 23;
   localparam logic [23:0] SAMPLES_MAX    = 24'hFFFFFF;

   typedef struct packed {
      logic trig;
      logic gate;
   } tick_type;

   typedef struct packed {
      logic [23:0] level;
      logic        end_pulse;
   } envelope_out_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'd0;  // [0] trigger_pulse, [1] gate_high
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [LEVEL_OUT_W-1:0] rsp_tdata;         // [23:0] level
   logic                  rsp_tlast;          // end_pulse
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = CSR_RUN_MODE;
   logic [SAMPLES_W-1:0]  csr_wdata  = '0;

   // Predictor state and its copy of the registers.
   env_stage_type env_stage  = ENV_IDLE;
   logic [23:0]   env_level  = '0;
   logic [1:0]    cfg_mode   = MODE_TRANSIENT;
   logic [23:0]   cfg_attack = '0;
   logic [23:0]   cfg_decay  = '0;

   tick_type         tick_q[$];
   envelope_out_type envelope_q[$];
   envelope_out_type want;
   tick_type         next_tick;
   int            mismatches = 0;
   int            send_gap   = 0;
   int            stall_left = 0;
   logic          calm       = 1'b0;
   logic          gate_held  = 1'b0;

   attack_decay_function_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [23:0] ramp_step(input logic [23:0] samples);
      logic [24:0] divisor;
      logic [24:0] quotient;
      divisor  = (samples == 24'd0) ? 25'd1 : {1'b0, samples};
      quotient = FULL_SCALE / divisor;
      return quotient[23:0];
   endfunction

   // One audio sample of the envelope; a trigger forces the attack stage first.
   function automatic envelope_out_type advance_envelope(input logic trig, input logic gate);
      envelope_out_type res;
      logic [23:0]   step;
      res.end_pulse = 1'b0;
      if (trig) env_stage = ENV_ATTACK;
      case (env_stage)
         ENV_ATTACK: begin
            step = ramp_step(cfg_attack);
            if ({1'b0, env_level} + step >= FULL_SCALE) begin
               env_level = FULL_SCALE[23:0];
               env_stage = (cfg_mode == MODE_SUSTAIN) ? ENV_SUSTAIN : ENV_DECAY;
            end else begin
               env_level = env_level + step;
            end
         end
         ENV_SUSTAIN: begin
            env_level = FULL_SCALE[23:0];
            if (!gate) env_stage = ENV_DECAY;
         end
         ENV_DECAY: begin
            step = ramp_step(cfg_decay);
            if (step >= env_level) begin
               env_level     = '0;
               res.end_pulse = 1'b1;
               env_stage     = (cfg_mode == MODE_CYCLE) ? ENV_ATTACK : ENV_IDLE;
            end else begin
               env_level = env_level - step;
            end
         end
         default: env_level = '0;
      endcase
      res.level = env_level;
      return res;
   endfunction

   // Driver: presents queued ticks, with random gaps while the channel is free.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            envelope_q.push_back(advance_envelope(req_tdata[0], req_tdata[1]));
         if (!req_tvalid || req_tready) begin
            if (send_gap != 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 3);
               req_tvalid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               next_tick = tick_q.pop_front();
               req_tdata  <= {6'b0, next_tick.gate, next_tick.trig};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat against the oldest prediction and stalls rsp_tready at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (envelope_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: level %0d end %0b", rsp_tdata, rsp_tlast);
            end else begin
               want = envelope_q.pop_front();
               if (rsp_tdata !== want.level || rsp_tlast !== want.end_pulse) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("level exp %0d got %0d, end exp %0b got %0b",
                              want.level, rsp_tdata, want.end_pulse, rsp_tlast);
               end
            end
         end
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RUN_MODE:       cfg_mode   = val[1:0];
         CSR_ATTACK_SAMPLES: cfg_attack = val;
         CSR_DECAY_SAMPLES:  cfg_decay  = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [23:0] mode_word, input logic [23:0] attack,
                             input logic [23:0] decay);
      write_reg(CSR_RUN_MODE, mode_word);
      write_reg(CSR_ATTACK_SAMPLES, attack);
      write_reg(CSR_DECAY_SAMPLES, decay);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every queued tick is sent and every prediction has been matched.
   task automatic drain();
      @(negedge clock);
      while (tick_q.size() != 0 || req_tvalid || envelope_q.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_tick(input logic trig, input logic gate);
      tick_q.push_back('{trig: trig, gate: gate});
   endtask

   function automatic logic [23:0] pick_samples();
      case ($urandom_range(0, 9))
         0:       return 24'd0;
         1:       return SAMPLES_MAX;
         2:       return 24'd8388608;
         3:       return 24'd8388609;
         4:       return 24'($urandom_range(0, 24'hFFFFFF));
         default: return 24'($urandom_range(1, 12));
      endcase
   endfunction

   initial begin
      logic [23:0] mode_word;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Transient with zero lengths, which act as one sample each.
      set_config({22'd0, MODE_TRANSIENT}, 24'd0, 24'd0);
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b1);
      drain();

      // Sustain holds full scale until the gate falls, then decays.
      set_config({22'd0, MODE_SUSTAIN}, 24'd3, 24'd2);
      push_tick(1'b1, 1'b1);
      repeat (4) push_tick(1'b0, 1'b1);
      repeat (3) push_tick(1'b0, 1'b0);
      drain();

      // Cycle mode, with a retrigger in the middle of a decay.
      set_config({22'd0, MODE_CYCLE}, 24'd2, 24'd4);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b0);
      push_tick(1'b1, 1'b0);
      repeat (5) push_tick(1'b0, 1'b0);
      drain();

      // Unused mode code and lengths beyond full scale, where the step is zero.
      set_config({22'd0, MODE_UNUSED}, SAMPLES_MAX, SAMPLES_MAX);
      push_tick(1'b1, 1'b1);
      push_tick(1'b0, 1'b0);
      push_tick(1'b0, 1'b1);
      drain();

      for (int phase = 0; phase < 20; phase++) begin
         if (phase >= 17) calm = 1'b1;
         mode_word      = 24'($urandom_range(0, 24'hFFFFFF));
         mode_word[1:0] = (phase < 4) ? phase[1:0] : 2'($urandom_range(0, 3));
         set_config(mode_word, pick_samples(), pick_samples());
         for (int n = 0; n < 34; n++) begin
            // Triggers are sparse so that most envelopes run to their end.
            if ($urandom_range(0, 5) == 0) gate_held = ~gate_held;
            push_tick($urandom_range(0, 15) == 0, gate_held);
         end
         drain();
      end

      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
